/* rtl/lfu_pkg.sv */
// Shared constants and types for the LFU cache table.
package lfu_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int OCC_W   = $clog2(ENTRIES + 1);
	localparam int KEY_W   = 16;
	localparam int VAL_W   = 16;
	localparam int CNT_W   = 16;
	localparam int CAP_W   = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);
	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

	localparam logic [2:0] OP_NOP    = 3'd0;
	localparam logic [2:0] OP_TOUCH  = 3'd1;
	localparam logic [2:0] OP_UPDATE = 3'd2;
	localparam logic [2:0] OP_EVICT  = 3'd3;
	localparam logic [2:0] OP_INSERT = 3'd4;

	typedef struct packed {
		logic [2:0]       op;
		logic [IDX_W-1:0] tgt;
		logic [IDX_W-1:0] ref_rank;
		logic [IDX_W-1:0] new_rank;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} cell_cmd_t;

	typedef struct packed {
		logic             valid;
		logic             match;
		logic [VAL_W-1:0] val;
		logic [CNT_W-1:0] cnt;
		logic [IDX_W-1:0] rank;
	} cell_stat_t;

endpackage

/* rtl/lfu_cache_table.sv */
// Top level: LFU cache table with LRU tie break over a row of entry cells.
// Get, put hit, ignored put: accept in IDLE, lookup in LOOK, result registered to the output from OUT.
// Put miss with room adds an INS state between LOOK and OUT.
// Put miss on a full table also adds a victim SCAN over all ENTRIES cells plus an EVICT state.
// A new transaction is accepted only in IDLE, after the previous result has left OUT; output stalls hold OUT.
// arst_n clears all valid marks, occupancy, control and sets capacity to ENTRIES.
module lfu_cache_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // lookup_key[15:0], write_value[31:16]
	input  logic [0:0]  s_tuser,   // mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // read_value
	output logic [0:0]  m_tuser    // hit
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOOK  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_EVICT = 3'd3;
	localparam logic [2:0] S_INS   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	localparam int N = lfu_pkg::ENTRIES;

	logic [2:0]                    state_q;
	logic [lfu_pkg::CAP_W-1:0]     cap_q;
	logic [lfu_pkg::OCC_W-1:0]     occ_q;
	logic                          mode_q;
	logic [lfu_pkg::KEY_W-1:0]     key_q;
	logic [lfu_pkg::VAL_W-1:0]     wval_q;
	logic                          hit_q;
	logic [lfu_pkg::VAL_W-1:0]     rval_q;
	logic [lfu_pkg::IDX_W-1:0]     scan_q;
	logic                          have_q;
	logic [lfu_pkg::IDX_W-1:0]     best_idx_q;
	logic [lfu_pkg::CNT_W-1:0]     best_cnt_q;
	logic [lfu_pkg::IDX_W-1:0]     best_rank_q;
	logic                          mvalid_q;
	logic [lfu_pkg::VAL_W-1:0]     mdata_q;
	logic                          mhit_q;

	lfu_pkg::cell_cmd_t            cmd;
	lfu_pkg::cell_stat_t           stat [N];
	logic [N:0]                    free_chain;

	logic                          found;
	logic [lfu_pkg::IDX_W-1:0]     hit_idx;
	logic [lfu_pkg::VAL_W-1:0]     hit_val;
	logic [lfu_pkg::IDX_W-1:0]     hit_rank;
	logic [lfu_pkg::OCC_W-1:0]     cap_eff;
	logic                          full;
	logic                          better;
	lfu_pkg::cell_stat_t           sc;

	assign free_chain[0] = 1'b0;

	for (genvar g = 0; g < N; g++) begin : g_cell
		lfu_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (lfu_pkg::IDX_W'(g)),
			.lookup_key (key_q),
			.cmd        (cmd),
			.free_in    (free_chain[g]),
			.free_out   (free_chain[g+1]),
			.stat       (stat[g])
		);
	end

	// keys are unique among valid cells, so an OR of matches suffices
	always_comb begin
		found    = 1'b0;
		hit_idx  = '0;
		hit_val  = '0;
		hit_rank = '0;
		for (int i = 0; i < N; i++) begin
			if (stat[i].match) begin
				found    = 1'b1;
				hit_idx  = lfu_pkg::IDX_W'(i);
				hit_val  = stat[i].val;
				hit_rank = stat[i].rank;
			end
		end
	end

	assign cap_eff = (cap_q > lfu_pkg::CAP_W'(N)) ? lfu_pkg::OCC_W'(N)
	                                              : lfu_pkg::OCC_W'(cap_q);
	assign full    = (occ_q >= cap_eff) && (occ_q != '0);
	assign sc      = stat[scan_q];
	assign better  = sc.valid && (!have_q || (sc.cnt < best_cnt_q) ||
	                 ((sc.cnt == best_cnt_q) && (sc.rank < best_rank_q)));

	always_comb begin
		cmd          = '0;
		cmd.op       = lfu_pkg::OP_NOP;
		cmd.key      = key_q;
		cmd.val      = wval_q;
		cmd.new_rank = lfu_pkg::IDX_W'(occ_q - 1'b1);
		case (state_q)
			S_LOOK: begin
				cmd.tgt      = hit_idx;
				cmd.ref_rank = hit_rank;
				if (found && !mode_q) cmd.op = lfu_pkg::OP_TOUCH;
				else if (found && cap_eff != '0) cmd.op = lfu_pkg::OP_UPDATE;
			end
			S_EVICT: begin
				cmd.op       = lfu_pkg::OP_EVICT;
				cmd.tgt      = best_idx_q;
				cmd.ref_rank = best_rank_q;
			end
			S_INS: begin
				cmd.op       = lfu_pkg::OP_INSERT;
				cmd.new_rank = lfu_pkg::IDX_W'(occ_q);
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = mvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = mhit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cap_q    <= lfu_pkg::CAP_RESET;
			occ_q    <= '0;
			scan_q   <= '0;
			have_q   <= 1'b0;
			mvalid_q <= 1'b0;
		end else begin
			if (cfg_we) cap_q <= cfg_wdata;
			if (state_q == S_OUT && (!mvalid_q || m_tready)) mvalid_q <= 1'b1;
			else if (mvalid_q && m_tready) mvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (s_tvalid) state_q <= S_LOOK;
				S_LOOK: begin
					scan_q <= '0;
					have_q <= 1'b0;
					if (!mode_q || found || cap_eff == '0) state_q <= S_OUT;
					else if (full) state_q <= S_SCAN;
					else state_q <= S_INS;
				end
				S_SCAN: begin
					if (better) have_q <= 1'b1;
					scan_q <= scan_q + 1'b1;
					if (scan_q == lfu_pkg::IDX_W'(N - 1)) state_q <= S_EVICT;
				end
				S_EVICT: begin
					if (have_q) occ_q <= occ_q - 1'b1;
					state_q <= S_INS;
				end
				S_INS: begin
					if (free_chain[N]) occ_q <= occ_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!mvalid_q || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			mode_q <= s_tuser[0];
			key_q  <= s_tdata[15:0];
			wval_q <= s_tdata[31:16];
		end
		if (state_q == S_LOOK) begin
			hit_q  <= found && (!mode_q || cap_eff != '0);
			rval_q <= (found && !mode_q) ? hit_val : '0;
		end
		if (state_q == S_SCAN && better) begin
			best_idx_q  <= scan_q;
			best_cnt_q  <= sc.cnt;
			best_rank_q <= sc.rank;
		end
		if (state_q == S_OUT && (!mvalid_q || m_tready)) begin
			mdata_q <= rval_q;
			mhit_q  <= hit_q;
		end
	end

endmodule

/* rtl/lfu_cell.sv */
// One cache entry: key, value, use count and recency rank.
module lfu_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [lfu_pkg::IDX_W-1:0]     idx,
	input  logic [lfu_pkg::KEY_W-1:0]     lookup_key,
	input  lfu_pkg::cell_cmd_t            cmd,
	input  logic                          free_in,
	output logic                          free_out,
	output lfu_pkg::cell_stat_t           stat
);

	logic                        valid_q;
	logic [lfu_pkg::KEY_W-1:0]   key_q;
	logic [lfu_pkg::VAL_W-1:0]   val_q;
	logic [lfu_pkg::CNT_W-1:0]   cnt_q;
	logic [lfu_pkg::IDX_W-1:0]   rank_q;
	logic                        is_tgt;
	logic                        claim;
	logic                        unlink;

	assign is_tgt   = (cmd.tgt == idx);
	// first free cell in the row claims an insert
	assign claim    = !valid_q && !free_in;
	assign free_out = free_in || !valid_q;
	assign unlink   = valid_q && !is_tgt && (rank_q > cmd.ref_rank);

	assign stat.valid = valid_q;
	assign stat.match = valid_q && (key_q == lookup_key);
	assign stat.val   = val_q;
	assign stat.cnt   = cnt_q;
	assign stat.rank  = rank_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (cmd.op)
				lfu_pkg::OP_EVICT:  if (is_tgt) valid_q <= 1'b0;
				lfu_pkg::OP_INSERT: if (claim) valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			lfu_pkg::OP_TOUCH, lfu_pkg::OP_UPDATE: begin
				if (is_tgt) begin
					rank_q <= cmd.new_rank;
					if (cnt_q != lfu_pkg::CNT_MAX) cnt_q <= cnt_q + 1'b1;
					if (cmd.op == lfu_pkg::OP_UPDATE) val_q <= cmd.val;
				end else if (unlink) begin
					rank_q <= rank_q - 1'b1;
				end
			end
			lfu_pkg::OP_EVICT: begin
				if (unlink) rank_q <= rank_q - 1'b1;
			end
			lfu_pkg::OP_INSERT: begin
				if (claim) begin
					key_q  <= cmd.key;
					val_q  <= cmd.val;
					cnt_q  <= lfu_pkg::CNT_W'(1);
					rank_q <= cmd.new_rank;
				end
			end
			default: ;
		endcase
	end

endmodule

/* dv/lfu_cache_table_tb.sv */
// Self-checking testbench for the LFU cache table with LRU tie break.
module lfu_cache_table_tb;

	localparam int ENTRIES = lfu_pkg::ENTRIES;
	localparam int KEY_W   = lfu_pkg::KEY_W;
	localparam int VAL_W   = lfu_pkg::VAL_W;
	localparam int CNT_W   = lfu_pkg::CNT_W;
	localparam logic [CNT_W-1:0] CNT_MAX = lfu_pkg::CNT_MAX;
	localparam logic [4:0] CAP_RESET = lfu_pkg::CAP_RESET;

	localparam logic MODE_GET = 1'b0;
	localparam logic MODE_PUT = 1'b1;
	localparam int CYCLE_LIMIT = 600000;
	localparam int ITEM_MAX = 4096;

	typedef struct packed {
		logic             mode;
		logic [VAL_W-1:0] wval;
		logic [KEY_W-1:0] key;
	} request_t;

	typedef struct packed {
		logic             hit;
		logic [VAL_W-1:0] rval;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;

	lfu_cache_table u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	// cache shadow
	logic [4:0]       cap_sh;
	logic             v_sh [ENTRIES];
	logic [KEY_W-1:0] k_sh [ENTRIES];
	logic [VAL_W-1:0] d_sh [ENTRIES];
	logic [CNT_W-1:0] c_sh [ENTRIES];
	int               r_sh [ENTRIES];
	int               occ_sh;

	// pending requests and expected responses, indexed by read and write counters
	request_t  req_mem [ITEM_MAX];
	response_t exp_mem [ITEM_MAX];
	int        req_wr = 0;
	int        req_rd = 0;
	int        exp_wr = 0;
	int        exp_rd = 0;
	logic      took = 1'b0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        err_cnt = 0;
	int        cycle_cnt = 0;

	function automatic void drop_rank(int s);
		for (int i = 0; i < ENTRIES; i++)
			if (v_sh[i] && i != s && r_sh[i] > r_sh[s])
				r_sh[i]--;
	endfunction

	function automatic void touch_entry(int s);
		drop_rank(s);
		r_sh[s] = occ_sh - 1;
		if (c_sh[s] != CNT_MAX)
			c_sh[s]++;
	endfunction

	function automatic response_t lookup_update(request_t rq);
		response_t rs;
		int cap, slot, victim;
		rs = '0;
		slot = -1;
		victim = -1;
		cap = (cap_sh > ENTRIES) ? ENTRIES : int'(cap_sh);
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && v_sh[i] && k_sh[i] == rq.key)
				slot = i;
		if (rq.mode == MODE_GET) begin
			if (slot >= 0) begin
				touch_entry(slot);
				rs.hit = 1'b1;
				rs.rval = d_sh[slot];
			end
			return rs;
		end
		if (cap == 0)
			return rs;
		if (slot >= 0) begin
			d_sh[slot] = rq.wval;
			touch_entry(slot);
			rs.hit = 1'b1;
			return rs;
		end
		if (occ_sh >= cap && occ_sh > 0) begin
			for (int i = 0; i < ENTRIES; i++)
				if (v_sh[i] && (victim < 0 || c_sh[i] < c_sh[victim] ||
						(c_sh[i] == c_sh[victim] && r_sh[i] < r_sh[victim])))
					victim = i;
			drop_rank(victim);
			v_sh[victim] = 1'b0;
			occ_sh--;
		end
		for (int i = 0; i < ENTRIES; i++)
			if (!v_sh[i]) begin
				v_sh[i] = 1'b1;
				k_sh[i] = rq.key;
				d_sh[i] = rq.wval;
				c_sh[i] = 1;
				r_sh[i] = occ_sh;
				occ_sh++;
				break;
			end
		return rs;
	endfunction

	// driver: a new transaction is offered once the previous one was taken
	always @(negedge clk) begin
		if ((!s_tvalid || took) && arst_n) begin
			if (req_rd < req_wr && $urandom_range(99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= {req_mem[req_rd].wval, req_mem[req_rd].key};
				s_tuser <= req_mem[req_rd].mode;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: input accepts feed the shadow model, results are checked in order
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		took = s_tvalid && s_tready;
		if (took) begin
			exp_mem[exp_wr] = lookup_update(req_mem[req_rd]);
			exp_wr++;
			req_rd++;
		end
		if (m_tvalid && m_tready) begin
			if (exp_rd == exp_wr) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("unexpected result hit=%0b value=%h", m_tuser, m_tdata);
			end else begin
				if (exp_mem[exp_rd].hit !== m_tuser[0] ||
						exp_mem[exp_rd].rval !== m_tdata) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("mismatch: exp hit=%0b value=%h got hit=%0b value=%h",
							exp_mem[exp_rd].hit, exp_mem[exp_rd].rval, m_tuser, m_tdata);
				end
				exp_rd++;
			end
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_req(logic mode, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval);
		request_t rq;
		rq.mode = mode;
		rq.key = key;
		rq.wval = wval;
		req_mem[req_wr] = rq;
		req_wr++;
	endtask

	// wait for the stream to drain, then let the block settle before a register write
	task automatic drain_and_config(logic [4:0] cap);
		wait (req_rd == req_wr && exp_rd == exp_wr);
		repeat (ENTRIES + 8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= cap;
		cap_sh = cap;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_phase(int n, int key_span);
		for (int i = 0; i < n; i++)
			add_req(1'($urandom_range(1)), ($urandom_range(15) == 0) ? 16'($urandom) :
				16'($urandom_range(key_span)), 16'($urandom));
	endtask

	initial begin
		cap_sh = CAP_RESET;
		occ_sh = 0;
		for (int i = 0; i < ENTRIES; i++) begin
			v_sh[i] = 1'b0;
			k_sh[i] = '0;
			d_sh[i] = '0;
			c_sh[i] = '0;
			r_sh[i] = 0;
		end
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, hits, overwrite, eviction with equal counts, saturation-free
		add_req(MODE_GET, 16'h0000, 16'hFFFF);
		add_req(MODE_PUT, 16'h0000, 16'hFFFF);
		add_req(MODE_PUT, 16'hFFFF, 16'h0000);
		add_req(MODE_GET, 16'hFFFF, 16'h1234);
		add_req(MODE_GET, 16'h0000, 16'h0000);
		add_req(MODE_PUT, 16'h0000, 16'hA5A5);
		add_req(MODE_GET, 16'h0000, 16'h0000);
		for (int i = 1; i <= 15; i++)
			add_req(MODE_PUT, 16'(i * 16'h1111 + 1), 16'(i));
		add_req(MODE_GET, 16'h1112, 16'h0);
		add_req(MODE_PUT, 16'h5A5A, 16'hBEEF);
		add_req(MODE_GET, 16'h5A5A, 16'h0);

		drain_and_config(5'd0);
		add_req(MODE_PUT, 16'h7777, 16'h1);
		add_req(MODE_GET, 16'h0000, 16'h0);
		add_req(MODE_GET, 16'h7777, 16'h0);

		drain_and_config(5'd2);
		add_req(MODE_PUT, 16'h4242, 16'h9);
		add_req(MODE_PUT, 16'h4343, 16'h8);
		random_phase(300, 7);

		drain_and_config(5'd31);
		send_idle_pct = 77;
		random_phase(300, 31);

		drain_and_config(5'd1);
		send_idle_pct = 0;
		recv_stall_pct = 77;
		random_phase(300, 3);

		drain_and_config(5'd16);
		send_idle_pct = 20;
		recv_stall_pct = 20;
		random_phase(400, 40);

		drain_and_config(5'd7);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_phase(450, 15);

		wait (req_rd == req_wr && exp_rd == exp_wr);
		repeat (ENTRIES + 10) @(negedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
